// ----- rtl/core/eeg_pp_pkg.sv -----
package eeg_pp_pkg;

    // Packet geometry
    localparam int MAX_PAYLOAD  = 169;
    localparam int BAND_COUNT   = 8;
    localparam int BAND_ROW_LEN = 2 + 3 * BAND_COUNT;
    localparam int PAY_AW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int BAND_AW      = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int POS_W        = $clog2(MAX_PAYLOAD + BAND_ROW_LEN + 1);

    // Byte values and row codes
    localparam logic [7:0] SYNC_BYTE       = 8'd170;
    localparam logic [7:0] CODE_QUALITY    = 8'd2;
    localparam logic [7:0] CODE_ATTENTION  = 8'd4;
    localparam logic [7:0] CODE_MEDITATION = 8'd5;
    localparam logic [7:0] CODE_RAW        = 8'h80;
    localparam logic [7:0] CODE_BANDS      = 8'h83;
    localparam logic [7:0] QUALITY_DEFAULT = 8'd200;

    // Receive framing phases
    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    // Payload walk and result emission states
    typedef enum logic [3:0] {
        W_IDLE,
        W_CODE_RD,
        W_CODE,
        W_VAL,
        W_BREQ,
        W_BCAP,
        W_EREQ,
        W_EOUT
    } walk_state_t;

    // One result item
    typedef struct packed {
        logic [7:0]  signal_quality;
        logic [7:0]  attention_level;
        logic [7:0]  meditation_level;
        logic [2:0]  band_index;
        logic [23:0] band_power;
        logic        last;
    } result_t;

endpackage

// ----- rtl/core/eeg_headset_packet_parser_core.sv -----
// Serial packet parser for an EEG headset byte stream.
// Input channel (s_valid/s_ready/s_rx_byte) takes one received byte per
// transaction. The framer hunts for two sync bytes, takes a length byte,
// stores the payload in a 169-entry byte RAM while summing it, and checks
// the checksum byte. On a good checksum a walker steps through the payload
// rows out of that RAM and then emits eight result transactions on the
// output channel (m_valid/m_ready/m_*), one per band, m_last on the eighth.
// Bad or oversized packets emit nothing.
// Throughput: one byte per cycle while framing. After a good checksum byte
// s_ready stays low while the walker reads each row code, the value byte of
// a level row and each band byte of a band-power row, then reads each band
// power back and loads it into the output register, one result at a time.
// The walk is bound by the single read port of the payload RAM. The first
// result appears once the walk reaches the payload end; the last result
// can be waiting while the next packet's bytes are taken.
// Reset clears the framer to the sync hunt and marks all band powers zero.
// A stalled receiver holds the output register and pauses the emission.
module eeg_headset_packet_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_signal_quality,
    output logic [7:0]  m_attention_level,
    output logic [7:0]  m_meditation_level,
    output logic [2:0]  m_band_index,
    output logic [23:0] m_band_power,
    output logic        m_last
);

    eeg_pp_pkg::phase_t phase_reg, phase_next;

    logic [7:0] len_reg, len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;

    logic                          accept;
    logic                          walk_busy;
    logic                          walk_start;
    logic                          pay_wr_en;
    logic                          pay_rd_en;
    logic [eeg_pp_pkg::PAY_AW-1:0] pay_rd_addr;
    logic [7:0]                    pay_rd_data;
    logic [8:0]                    count_inc;
    eeg_pp_pkg::result_t           res;

    assign s_ready   = !walk_busy;
    assign accept    = s_valid && s_ready;
    assign count_inc = {1'b0, count_reg} + 9'd1;

    // Framing next state
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                eeg_pp_pkg::PH_SYNC1: begin
                    if (s_rx_byte == eeg_pp_pkg::SYNC_BYTE) phase_next = eeg_pp_pkg::PH_SYNC2;
                end
                eeg_pp_pkg::PH_SYNC2: begin
                    phase_next = (s_rx_byte == eeg_pp_pkg::SYNC_BYTE) ?
                                 eeg_pp_pkg::PH_LEN : eeg_pp_pkg::PH_SYNC1;
                end
                eeg_pp_pkg::PH_LEN: begin
                    if (s_rx_byte > 8'(eeg_pp_pkg::MAX_PAYLOAD)) begin
                        phase_next = eeg_pp_pkg::PH_SYNC1;
                    end else if (s_rx_byte == 8'd0) begin
                        phase_next = eeg_pp_pkg::PH_CHECK;
                    end else begin
                        phase_next = eeg_pp_pkg::PH_DATA;
                    end
                end
                eeg_pp_pkg::PH_DATA: begin
                    if (count_inc >= {1'b0, len_reg}) phase_next = eeg_pp_pkg::PH_CHECK;
                end
                default: phase_next = eeg_pp_pkg::PH_SYNC1;
            endcase
        end
    end

    // Framing counters, payload write and walk launch
    always_comb begin
        len_next   = len_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        pay_wr_en  = 1'b0;
        walk_start = 1'b0;
        if (accept) begin
            case (phase_reg)
                eeg_pp_pkg::PH_LEN: begin
                    if (s_rx_byte <= 8'(eeg_pp_pkg::MAX_PAYLOAD)) begin
                        len_next   = s_rx_byte;
                        count_next = 8'd0;
                        sum_next   = 8'd0;
                    end
                end
                eeg_pp_pkg::PH_DATA: begin
                    pay_wr_en  = 1'b1;
                    sum_next   = sum_reg + s_rx_byte;
                    count_next = count_inc[7:0];
                end
                eeg_pp_pkg::PH_CHECK: begin
                    walk_start = s_rx_byte == ~sum_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= eeg_pp_pkg::PH_SYNC1;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            sum_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Payload store
    eeg_pp_ram #(
        .WIDTH (8),
        .DEPTH (eeg_pp_pkg::MAX_PAYLOAD)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (pay_wr_en),
        .wr_addr (count_reg[eeg_pp_pkg::PAY_AW-1:0]),
        .wr_data (s_rx_byte),
        .rd_en   (pay_rd_en),
        .rd_addr (pay_rd_addr),
        .rd_data (pay_rd_data)
    );

    // Row walk and result emission
    eeg_pp_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (walk_start),
        .pkt_len     (len_reg),
        .busy        (walk_busy),
        .pay_rd_en   (pay_rd_en),
        .pay_rd_addr (pay_rd_addr),
        .pay_rd_data (pay_rd_data),
        .res         (res),
        .res_valid   (m_valid),
        .res_ready   (m_ready)
    );

    assign m_signal_quality   = res.signal_quality;
    assign m_attention_level  = res.attention_level;
    assign m_meditation_level = res.meditation_level;
    assign m_band_index       = res.band_index;
    assign m_band_power       = res.band_power;
    assign m_last             = res.last;

endmodule

// ----- rtl/core/eeg_pp_ram.sv -----
module eeg_pp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/eeg_pp_walker.sv -----
module eeg_pp_walker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [7:0]                     pkt_len,
    output logic                           busy,
    output logic                           pay_rd_en,
    output logic [eeg_pp_pkg::PAY_AW-1:0]  pay_rd_addr,
    input  logic [7:0]                     pay_rd_data,
    output eeg_pp_pkg::result_t            res,
    output logic                           res_valid,
    input  logic                           res_ready
);

    localparam int PW = eeg_pp_pkg::POS_W;
    localparam int BW = eeg_pp_pkg::BAND_AW;

    typedef logic [eeg_pp_pkg::PAY_AW-1:0] pay_addr_t;

    eeg_pp_pkg::walk_state_t state_reg, state_next;

    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       code_reg, code_next;
    logic [PW-1:0]    bptr_reg, bptr_next;
    logic [1:0]       j_reg, j_next;
    logic [BW-1:0]    k_reg, k_next;
    logic [15:0]      acc_reg, acc_next;
    logic [7:0]       qual_reg, qual_next;
    logic [7:0]       attn_reg, attn_next;
    logic [7:0]       med_reg, med_next;
    logic [eeg_pp_pkg::BAND_COUNT-1:0] bvalid_reg, bvalid_next;
    eeg_pp_pkg::result_t res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    logic             band_wr_en;
    logic             band_rd_en;
    logic [23:0]      band_rd_data;
    logic [PW:0]      pos_ext;
    logic [PW:0]      len_ext;
    logic             pos_in_range;
    logic             fits_pair;
    logic             fits_bands;
    logic             k_last;
    logic             out_free;

    assign pos_ext      = {1'b0, pos_reg};
    assign len_ext      = (PW + 1)'(len_reg);
    assign pos_in_range = pos_ext < len_ext;
    assign fits_pair    = (pos_ext + (PW + 1)'(2)) <= len_ext;
    assign fits_bands   = (pos_ext + (PW + 1)'(eeg_pp_pkg::BAND_ROW_LEN)) <= len_ext;
    assign k_last       = k_reg == BW'(eeg_pp_pkg::BAND_COUNT - 1);
    assign out_free     = !res_valid_reg || res_ready;

    // Band power store
    eeg_pp_ram #(
        .WIDTH (24),
        .DEPTH (eeg_pp_pkg::BAND_COUNT)
    ) u_band_ram (
        .aclk    (aclk),
        .wr_en   (band_wr_en),
        .wr_addr (k_reg),
        .wr_data ({acc_reg, pay_rd_data}),
        .rd_en   (band_rd_en),
        .rd_addr (k_reg),
        .rd_data (band_rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            eeg_pp_pkg::W_IDLE: begin
                if (start) state_next = eeg_pp_pkg::W_CODE_RD;
            end
            eeg_pp_pkg::W_CODE_RD: begin
                state_next = pos_in_range ? eeg_pp_pkg::W_CODE : eeg_pp_pkg::W_EREQ;
            end
            eeg_pp_pkg::W_CODE: begin
                state_next = eeg_pp_pkg::W_CODE_RD;
                case (pay_rd_data)
                    eeg_pp_pkg::CODE_QUALITY,
                    eeg_pp_pkg::CODE_ATTENTION,
                    eeg_pp_pkg::CODE_MEDITATION: begin
                        if (fits_pair) state_next = eeg_pp_pkg::W_VAL;
                    end
                    eeg_pp_pkg::CODE_BANDS: begin
                        if (fits_bands) state_next = eeg_pp_pkg::W_BREQ;
                    end
                    default: state_next = eeg_pp_pkg::W_CODE_RD;
                endcase
            end
            eeg_pp_pkg::W_VAL:  state_next = eeg_pp_pkg::W_CODE_RD;
            eeg_pp_pkg::W_BREQ: state_next = eeg_pp_pkg::W_BCAP;
            eeg_pp_pkg::W_BCAP: begin
                if (j_reg == 2'd2 && k_last) state_next = eeg_pp_pkg::W_CODE_RD;
                else                         state_next = eeg_pp_pkg::W_BREQ;
            end
            eeg_pp_pkg::W_EREQ: state_next = eeg_pp_pkg::W_EOUT;
            eeg_pp_pkg::W_EOUT: begin
                if (out_free) state_next = k_last ? eeg_pp_pkg::W_IDLE : eeg_pp_pkg::W_EREQ;
            end
            default: state_next = eeg_pp_pkg::W_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        pos_next       = pos_reg;
        len_next       = len_reg;
        code_next      = code_reg;
        bptr_next      = bptr_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        qual_next      = qual_reg;
        attn_next      = attn_reg;
        med_next       = med_reg;
        bvalid_next    = bvalid_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        pay_rd_en      = 1'b0;
        pay_rd_addr    = pos_reg[eeg_pp_pkg::PAY_AW-1:0];
        band_wr_en     = 1'b0;
        band_rd_en     = 1'b0;
        case (state_reg)
            eeg_pp_pkg::W_IDLE: begin
                // Load packet defaults
                if (start) begin
                    pos_next  = '0;
                    len_next  = pkt_len;
                    qual_next = eeg_pp_pkg::QUALITY_DEFAULT;
                    attn_next = 8'd0;
                    med_next  = 8'd0;
                end
            end
            eeg_pp_pkg::W_CODE_RD: begin
                // Fetch the row code, or start emission at payload end
                if (pos_in_range) begin
                    pay_rd_en = 1'b1;
                end else begin
                    k_next = '0;
                end
            end
            eeg_pp_pkg::W_CODE: begin
                code_next = pay_rd_data;
                case (pay_rd_data)
                    eeg_pp_pkg::CODE_QUALITY,
                    eeg_pp_pkg::CODE_ATTENTION,
                    eeg_pp_pkg::CODE_MEDITATION: begin
                        pay_rd_en   = fits_pair;
                        pay_rd_addr = pay_addr_t'(pos_reg + PW'(1));
                        pos_next    = pos_reg + PW'(2);
                    end
                    eeg_pp_pkg::CODE_RAW: begin
                        pos_next = pos_reg + PW'(4);
                    end
                    eeg_pp_pkg::CODE_BANDS: begin
                        bptr_next = pos_reg + PW'(2);
                        j_next    = 2'd0;
                        k_next    = '0;
                        pos_next  = pos_reg + PW'(eeg_pp_pkg::BAND_ROW_LEN);
                    end
                    default: pos_next = pos_reg + PW'(1);
                endcase
            end
            eeg_pp_pkg::W_VAL: begin
                // Take the single-byte value
                case (code_reg)
                    eeg_pp_pkg::CODE_QUALITY:   qual_next = pay_rd_data;
                    eeg_pp_pkg::CODE_ATTENTION: attn_next = pay_rd_data;
                    default:                    med_next  = pay_rd_data;
                endcase
            end
            eeg_pp_pkg::W_BREQ: begin
                pay_rd_en   = 1'b1;
                pay_rd_addr = bptr_reg[eeg_pp_pkg::PAY_AW-1:0];
            end
            eeg_pp_pkg::W_BCAP: begin
                // Shift in one big-endian byte, store on the third
                acc_next  = {acc_reg[7:0], pay_rd_data};
                bptr_next = bptr_reg + PW'(1);
                if (j_reg == 2'd2) begin
                    j_next             = 2'd0;
                    band_wr_en         = 1'b1;
                    bvalid_next[k_reg] = 1'b1;
                    if (!k_last) k_next = k_reg + BW'(1);
                end else begin
                    j_next = j_reg + 2'd1;
                end
            end
            eeg_pp_pkg::W_EREQ: begin
                band_rd_en = 1'b1;
            end
            eeg_pp_pkg::W_EOUT: begin
                // Load the output register when it frees up
                if (out_free) begin
                    res_next.signal_quality   = qual_reg;
                    res_next.attention_level  = attn_reg;
                    res_next.meditation_level = med_reg;
                    res_next.band_index       = 3'(k_reg);
                    res_next.band_power       = bvalid_reg[k_reg] ? band_rd_data : 24'd0;
                    res_next.last             = k_last;
                    res_valid_next            = 1'b1;
                    if (!k_last) k_next = k_reg + BW'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= eeg_pp_pkg::W_IDLE;
            bvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bvalid_reg    <= bvalid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        len_reg  <= len_next;
        code_reg <= code_next;
        bptr_reg <= bptr_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        qual_reg <= qual_next;
        attn_reg <= attn_next;
        med_reg  <= med_next;
        res_reg  <= res_next;
    end

    assign busy      = state_reg != eeg_pp_pkg::W_IDLE;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 4 * eeg_pp_pkg::MAX_PAYLOAD + 100;
    localparam int END_WAIT     = 20000;
    localparam int PHASE_BYTES  = 20;

    logic        aclk               = 1'b0;
    logic        aresetn            = 1'b0;
    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte          = 8'h00;
    logic        m_valid;
    logic        m_ready            = 1'b0;
    logic [7:0]  m_signal_quality;
    logic [7:0]  m_attention_level;
    logic [7:0]  m_meditation_level;
    logic [2:0]  m_band_index;
    logic [23:0] m_band_power;
    logic        m_last;

    // Stimulus and scoreboard storage
    logic [7:0]  rx_bytes_q[$];
    logic [7:0]  body_q[$];
    eeg_pp_pkg::result_t pending_reports[$];
    bit          rx_held        = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Counters
    int unsigned mismatches      = 0;
    int unsigned bytes_taken     = 0;
    int unsigned reports_checked = 0;
    int unsigned good_packets    = 0;
    int unsigned packets_queued  = 0;
    int unsigned random_bytes    = 0;

    // Parser state mirror
    eeg_pp_pkg::phase_t rx_phase = eeg_pp_pkg::PH_SYNC1;
    int unsigned pkt_len  = 0;
    int unsigned pay_cnt  = 0;
    logic [7:0]  pay_sum  = 8'h00;
    logic [7:0]  pay_mem  [eeg_pp_pkg::MAX_PAYLOAD];
    logic [23:0] band_mem [eeg_pp_pkg::BAND_COUNT];

    eeg_headset_packet_parser_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_signal_quality   (m_signal_quality),
        .m_attention_level  (m_attention_level),
        .m_meditation_level (m_meditation_level),
        .m_band_index       (m_band_index),
        .m_band_power       (m_band_power),
        .m_last             (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                    reports_checked, name, got, want));
        end
    endtask

    // Walk the stored payload rows and queue one report per band
    task automatic walk_payload();
        int unsigned pos;
        int unsigned left;
        int unsigned base;
        logic [7:0]  code;
        logic [7:0]  quality;
        logic [7:0]  attention;
        logic [7:0]  meditation;
        eeg_pp_pkg::result_t rpt;
        pos        = 0;
        quality    = eeg_pp_pkg::QUALITY_DEFAULT;
        attention  = 8'h00;
        meditation = 8'h00;
        while (pos < pkt_len) begin
            code = pay_mem[pos];
            left = pkt_len - pos;
            if (code == eeg_pp_pkg::CODE_QUALITY || code == eeg_pp_pkg::CODE_ATTENTION ||
                code == eeg_pp_pkg::CODE_MEDITATION) begin
                if (left >= 2) begin
                    if (code == eeg_pp_pkg::CODE_QUALITY) quality = pay_mem[pos + 1];
                    else if (code == eeg_pp_pkg::CODE_ATTENTION) attention = pay_mem[pos + 1];
                    else meditation = pay_mem[pos + 1];
                end
                pos += 2;
            end else if (code == eeg_pp_pkg::CODE_RAW) begin
                pos += 4;
            end else if (code == eeg_pp_pkg::CODE_BANDS) begin
                // load powers only when the whole row fits in the payload
                if (left >= eeg_pp_pkg::BAND_ROW_LEN) begin
                    base = pos + 2;
                    for (int k = 0; k < eeg_pp_pkg::BAND_COUNT; k++) begin
                        band_mem[k] = {pay_mem[base], pay_mem[base + 1], pay_mem[base + 2]};
                        base += 3;
                    end
                end
                pos += eeg_pp_pkg::BAND_ROW_LEN;
            end else begin
                pos += 1;
            end
        end
        for (int k = 0; k < eeg_pp_pkg::BAND_COUNT; k++) begin
            rpt.signal_quality   = quality;
            rpt.attention_level  = attention;
            rpt.meditation_level = meditation;
            rpt.band_index       = 3'(k);
            rpt.band_power       = band_mem[k];
            rpt.last             = (k == eeg_pp_pkg::BAND_COUNT - 1);
            pending_reports.push_back(rpt);
        end
        good_packets++;
    endtask

    // Advance the framing mirror by one received byte
    task automatic track_rx_byte(input logic [7:0] b);
        case (rx_phase)
            eeg_pp_pkg::PH_SYNC1: begin
                if (b == eeg_pp_pkg::SYNC_BYTE) rx_phase = eeg_pp_pkg::PH_SYNC2;
            end
            eeg_pp_pkg::PH_SYNC2: begin
                rx_phase = (b == eeg_pp_pkg::SYNC_BYTE) ? eeg_pp_pkg::PH_LEN :
                                                          eeg_pp_pkg::PH_SYNC1;
            end
            eeg_pp_pkg::PH_LEN: begin
                if (b > eeg_pp_pkg::MAX_PAYLOAD) begin
                    rx_phase = eeg_pp_pkg::PH_SYNC1;
                end else begin
                    pkt_len  = 32'(b);
                    pay_cnt  = 0;
                    pay_sum  = 8'h00;
                    rx_phase = (b == 8'h00) ? eeg_pp_pkg::PH_CHECK : eeg_pp_pkg::PH_DATA;
                end
            end
            eeg_pp_pkg::PH_DATA: begin
                pay_mem[pay_cnt] = b;
                pay_sum = pay_sum + b;
                pay_cnt++;
                if (pay_cnt >= pkt_len) rx_phase = eeg_pp_pkg::PH_CHECK;
            end
            eeg_pp_pkg::PH_CHECK: begin
                rx_phase = eeg_pp_pkg::PH_SYNC1;
                if (b == 8'(8'hFF - pay_sum)) walk_payload();
            end
            default: begin
                rx_phase = eeg_pp_pkg::PH_SYNC1;
            end
        endcase
    endtask

    function automatic logic [7:0] any_but_sync();
        logic [7:0] v;
        do v = 8'($urandom); while (v == eeg_pp_pkg::SYNC_BYTE);
        return v;
    endfunction

    // Frame the current body with sync, length and checksum
    task automatic queue_packet(input bit corrupt);
        logic [7:0] sum;
        sum = 8'h00;
        rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
        rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
        rx_bytes_q.push_back(8'(body_q.size()));
        foreach (body_q[i]) begin
            sum += body_q[i];
            rx_bytes_q.push_back(body_q[i]);
        end
        sum = 8'hFF - sum;
        if (corrupt) sum ^= 8'($urandom_range(1, 255));
        rx_bytes_q.push_back(sum);
        packets_queued++;
    endtask

    // Append a band-power row, cut to keep bytes
    task automatic put_band_row(input int keep, input logic [7:0] fill, input bit rand_fill);
        logic [7:0] v;
        for (int n = 0; n < keep && n < eeg_pp_pkg::BAND_ROW_LEN; n++) begin
            if (n == 0) v = eeg_pp_pkg::CODE_BANDS;
            else if (rand_fill) v = 8'($urandom);
            else v = fill;
            body_q.push_back(v);
        end
    endtask

    task automatic queue_random_packet();
        int unsigned target;
        int unsigned pick;
        body_q.delete();
        pick = $urandom_range(24);
        if (pick == 0) begin
            target = $urandom_range(100, eeg_pp_pkg::MAX_PAYLOAD);
        end else if (pick < 10) begin
            target = $urandom_range(eeg_pp_pkg::BAND_ROW_LEN, eeg_pp_pkg::BAND_ROW_LEN + 20);
        end else begin
            target = $urandom_range(0, 20);
        end
        while (body_q.size() < target) begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2: begin
                    body_q.push_back((pick == 0) ? eeg_pp_pkg::CODE_QUALITY :
                                     (pick == 1) ? eeg_pp_pkg::CODE_ATTENTION :
                                                   eeg_pp_pkg::CODE_MEDITATION);
                    body_q.push_back(8'($urandom));
                end
                3: begin
                    body_q.push_back(eeg_pp_pkg::CODE_RAW);
                    repeat (3) body_q.push_back(8'($urandom));
                end
                4, 5: begin
                    put_band_row(eeg_pp_pkg::BAND_ROW_LEN, 8'h00, 1'b1);
                end
                default: begin
                    body_q.push_back(8'($urandom));
                end
            endcase
        end
        // cut the tail so the last row may be truncated
        while (body_q.size() > target) void'(body_q.pop_back());
        random_bytes += target + 4;
        queue_packet($urandom_range(99) < 15);
    endtask

    // Broken headers and line noise between packets
    task automatic queue_noise();
        case ($urandom_range(2))
            0: begin
                repeat ($urandom_range(1, 3)) rx_bytes_q.push_back(any_but_sync());
            end
            1: begin
                rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
                rx_bytes_q.push_back(any_but_sync());
            end
            default: begin
                rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
                rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
                rx_bytes_q.push_back(8'($urandom_range(eeg_pp_pkg::MAX_PAYLOAD + 1, 255)));
            end
        endcase
    endtask

    task automatic queue_directed();
        // empty payload with good and bad checksum
        body_q.delete();
        queue_packet(1'b0);
        queue_packet(1'b1);
        // level rows at extremes, a raw row and a stray byte
        body_q = {eeg_pp_pkg::CODE_QUALITY, 8'h00, eeg_pp_pkg::CODE_ATTENTION, 8'hFF,
                  eeg_pp_pkg::CODE_MEDITATION, 8'h80, eeg_pp_pkg::CODE_RAW, 8'hAA, 8'h55,
                  8'hFF, 8'h7E};
        queue_packet(1'b0);
        // band rows: all ones, then all zeros followed by a quality row
        body_q.delete();
        put_band_row(eeg_pp_pkg::BAND_ROW_LEN, 8'hFF, 1'b0);
        queue_packet(1'b0);
        body_q.delete();
        put_band_row(eeg_pp_pkg::BAND_ROW_LEN, 8'h00, 1'b0);
        body_q.push_back(eeg_pp_pkg::CODE_QUALITY);
        body_q.push_back(8'h01);
        queue_packet(1'b0);
        // band row cut by the payload end leaves powers alone
        body_q.delete();
        put_band_row(20, 8'h00, 1'b1);
        queue_packet(1'b0);
        // level row and raw row cut by the payload end
        body_q = {eeg_pp_pkg::CODE_ATTENTION, 8'h12, eeg_pp_pkg::CODE_QUALITY};
        queue_packet(1'b0);
        body_q = {eeg_pp_pkg::CODE_MEDITATION, 8'h33, eeg_pp_pkg::CODE_RAW, 8'h01};
        queue_packet(1'b0);
        // one-byte payload holding a sync value
        body_q = {eeg_pp_pkg::SYNC_BYTE};
        queue_packet(1'b0);
        // largest payload
        body_q.delete();
        put_band_row(eeg_pp_pkg::BAND_ROW_LEN, 8'h00, 1'b1);
        while (body_q.size() < eeg_pp_pkg::MAX_PAYLOAD) body_q.push_back(8'($urandom));
        queue_packet(1'b0);
        // second byte not sync, length just over the limit, length at top
        rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
        rx_bytes_q.push_back(8'h55);
        rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
        rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
        rx_bytes_q.push_back(8'(eeg_pp_pkg::MAX_PAYLOAD + 1));
        rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
        rx_bytes_q.push_back(eeg_pp_pkg::SYNC_BYTE);
        rx_bytes_q.push_back(8'hFF);
        body_q = {eeg_pp_pkg::CODE_QUALITY, 8'h64};
        queue_packet(1'b0);
    endtask

    // Driver: present bytes and back-pressure at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!rx_held) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_rx_byte <= rx_bytes_q.pop_front();
                s_valid   <= 1'b1;
                rx_held = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted bytes, check each result transaction
    always @(posedge aclk) begin
        eeg_pp_pkg::result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                track_rx_byte(s_rx_byte);
                rx_held = 1'b0;
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, band %0d power 0x%0h",
                                            m_band_index, m_band_power));
                end else begin
                    want = pending_reports.pop_front();
                    check_field("signal_quality", 24'(m_signal_quality),
                                24'(want.signal_quality));
                    check_field("attention_level", 24'(m_attention_level),
                                24'(want.attention_level));
                    check_field("meditation_level", 24'(m_meditation_level),
                                24'(want.meditation_level));
                    check_field("band_index", 24'(m_band_index), 24'(want.band_index));
                    check_field("band_power", m_band_power, want.band_power);
                    check_field("last", 24'(m_last), 24'(want.last));
                end
                reports_checked++;
            end
        end
    end

    // Stimulus sequence
    initial begin
        int unsigned n;
        foreach (pay_mem[i]) pay_mem[i] = 8'h00;
        foreach (band_mem[i]) band_mem[i] = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (ph == 0) begin
                queue_directed();
            end else begin
                random_bytes = 0;
                while (random_bytes < PHASE_BYTES) begin
                    if ($urandom_range(9) < 3) queue_noise();
                    queue_random_packet();
                end
            end
            while (rx_bytes_q.size() != 0 || rx_held) @(posedge aclk);
        end

        // Drain remaining results, then let the walker settle
        for (n = 0; n < END_WAIT && pending_reports.size() != 0; n++) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_reports.size()));
        end

        $display("Run covered %0d bytes in %0d framed packets, %0d with a good checksum.",
                 bytes_taken, packets_queued, good_packets);
        $display("Checked %0d results over four idle/stall mixes, %0d mismatches.",
                 reports_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
